// ----- sv/prnp_pkg.sv -----
// Shared types and constants for the prefixed radix number parser.
// No dependencies; the step, format, core and verification files import this package.
package prnp_pkg;

	// Width of the machine word for octal, hex and full-length binary tokens
	localparam int WORD_BITS = 32;

	localparam logic [7:0] CH_BIN   = 8'h62; // 'b'
	localparam logic [7:0] CH_OCT   = 8'h6f; // 'o'
	localparam logic [7:0] CH_HEX   = 8'h78; // 'x'
	localparam logic [7:0] CH_DEC   = 8'h64; // 'd'
	localparam logic [7:0] CH_MINUS = 8'h2d; // '-'
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;

	localparam logic [6:0] COUNT_MAX = 7'd127;

	typedef enum logic [2:0] {
		MODE_PREFIX,
		MODE_BIN,
		MODE_OCT,
		MODE_HEX,
		MODE_DEC,
		MODE_MINUS,
		MODE_REJECT
	} mode_t;

	typedef enum logic [1:0] {
		ERR_OK,
		ERR_BAD_DIGIT,
		ERR_NEG_NONDEC,
		ERR_UNKNOWN_BASE
	} err_t;

	typedef struct packed {
		mode_t       mode;
		logic        neg;
		logic [63:0] acc;
		logic [6:0]  count;
		err_t        err;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		mode:  MODE_PREFIX,
		neg:   1'b0,
		acc:   64'd0,
		count: 7'd0,
		err:   ERR_OK
	};

endpackage

// ----- sv/prnp_char_if.sv -----
// Character channel of the number parser: valid/ready with one character
// and its last flag. No dependencies.
interface prnp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- sv/prnp_result_if.sv -----
// Result channel of the number parser: valid/ready with the parsed value
// and its error code. No dependencies.
interface prnp_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  error_code;

	modport source (output valid, output value, output error_code, input ready);
	modport sink (input valid, input value, input error_code, output ready);
endinterface

// ----- sv/prnp_step.sv -----
// Next-state logic for one character: prefix decode, digit decode and
// accumulator update. Depends on prnp_pkg.
module prnp_step import prnp_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   char_code,
	output parse_state_t nxt,
	output parse_state_t fin
);

	logic       is_dec_digit;
	logic       is_lc_hex;
	logic       is_uc_hex;
	logic       digit_ok;
	logic [3:0] digit;

	always_comb begin
		is_dec_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_lc_hex    = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);
		is_uc_hex    = (char_code >= CH_UC_A) && (char_code <= CH_UC_F);
		// low nibble of '0'..'9' is the digit; 'a'/'A' low nibble is 1
		digit = is_dec_digit ? char_code[3:0] : 4'(char_code[3:0] + 4'd9);
		case (cur.mode)
			MODE_BIN: digit_ok = is_dec_digit && (char_code[3:1] == 3'd0);
			MODE_OCT: digit_ok = is_dec_digit && !char_code[3];
			MODE_HEX: digit_ok = is_dec_digit || is_lc_hex || is_uc_hex;
			MODE_DEC: digit_ok = is_dec_digit;
			default:  digit_ok = 1'b0;
		endcase
	end

	always_comb begin
		nxt = cur;
		case (cur.mode)
			MODE_PREFIX: begin
				if (char_code == CH_BIN) begin
					nxt.mode = MODE_BIN;
				end else if (char_code == CH_OCT) begin
					nxt.mode = MODE_OCT;
				end else if (char_code == CH_HEX) begin
					nxt.mode = MODE_HEX;
				end else if (char_code == CH_DEC) begin
					nxt.mode = MODE_DEC;
				end else if (char_code == CH_MINUS) begin
					nxt.mode = MODE_MINUS;
					nxt.neg  = 1'b1;
				end else begin
					nxt.mode = MODE_REJECT;
					nxt.err  = ERR_UNKNOWN_BASE;
				end
			end
			MODE_MINUS: begin
				if (char_code == CH_DEC) begin
					nxt.mode = MODE_DEC;
				end else begin
					nxt.mode = MODE_REJECT;
					nxt.err  = ERR_NEG_NONDEC;
				end
			end
			MODE_BIN, MODE_OCT, MODE_HEX, MODE_DEC: begin
				if (!digit_ok) begin
					if (cur.err == ERR_OK)
						nxt.err = ERR_BAD_DIGIT;
				end else begin
					case (cur.mode)
						MODE_BIN: nxt.acc = {cur.acc[62:0], 1'b0} + 64'(digit);
						MODE_OCT: nxt.acc = {cur.acc[60:0], 3'd0} + 64'(digit);
						MODE_HEX: nxt.acc = {cur.acc[59:0], 4'd0} + 64'(digit);
						default:  nxt.acc = {cur.acc[60:0], 3'd0} + {cur.acc[62:0], 1'b0}
							+ 64'(digit);
					endcase
					if (cur.count != COUNT_MAX)
						nxt.count = cur.count + 7'd1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// a token that stops right after '-' counts as negative non-decimal
	always_comb begin
		fin = nxt;
		if (nxt.mode == MODE_MINUS)
			fin.err = ERR_NEG_NONDEC;
	end

endmodule

// ----- sv/prnp_fmt.sv -----
// Result formatting: word sign extension, binary two's complement reading
// and decimal negation of a finished token. Depends on prnp_pkg.
module prnp_fmt import prnp_pkg::*; (
	input  parse_state_t fin,
	output logic [63:0]  value,
	output logic [1:0]   error_code
);

	logic [63:0] word_ext;
	logic        word_sign;

	always_comb begin
		word_sign = fin.acc[WORD_BITS-1];
		for (int i = 0; i < 64; i++)
			word_ext[i] = (i < WORD_BITS) ? fin.acc[i] : word_sign;
	end

	always_comb begin
		error_code = 2'(fin.err);
		if (fin.err == ERR_NEG_NONDEC || fin.err == ERR_UNKNOWN_BASE) begin
			value = 64'd0;
		end else begin
			case (fin.mode)
				MODE_BIN: value = (fin.count == 7'(WORD_BITS)) ? word_ext : fin.acc;
				MODE_OCT, MODE_HEX: value = word_ext;
				MODE_DEC: value = fin.neg ? 64'(64'd0 - fin.acc) : fin.acc;
				default: value = 64'd0;
			endcase
		end
	end

endmodule

// ----- sv/prefixed_radix_number_parser_core.sv -----
// Prefixed radix number parser.
// chars: one ASCII character per item, prefix first ('b', 'o', 'x', 'd' or
// '-' then 'd'), with last_char set on the final character of the token.
// results: one item per token, the signed 64-bit value and a 2-bit error
// code (ok, bad digit skipped, negative non-decimal, unknown base).
// Throughput: one character per cycle, tokens back to back, while results
// are taken; each character updates the registered parse state: a shift or a
// times-ten add of the accumulator.
// One register holds the finished token, the next the formatted result
// (sign extension or negation), which drives the result channel.
// When results.ready is low the finished token and result registers hold
// and chars.ready drops once both are full; characters taken before that
// keep parsing the next token.
// Reset (arst_n low) clears the parse state and empties both registers.
// Depends on prnp_pkg, prnp_char_if, prnp_result_if, prnp_step, prnp_fmt.
module prefixed_radix_number_parser_core import prnp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	prnp_char_if.sink            chars,
	prnp_result_if.source        results
);

	parse_state_t state_q;
	parse_state_t step_nxt;
	parse_state_t step_fin;
	parse_state_t fin_s1;
	logic         valid_s1;
	logic [63:0]  fmt_value;
	logic [1:0]   fmt_err;
	logic         valid_s2;
	logic [63:0]  value_s2;
	logic [1:0]   err_s2;
	logic         in_take;
	logic         adv_s2;

	prnp_step u_step (
		.cur       (state_q),
		.char_code (chars.char_code),
		.nxt       (step_nxt),
		.fin       (step_fin)
	);

	prnp_fmt u_fmt (
		.fin        (fin_s1),
		.value      (fmt_value),
		.error_code (fmt_err)
	);

	assign adv_s2      = valid_s1 && (!valid_s2 || results.ready);
	assign chars.ready = !valid_s1 || adv_s2;
	assign in_take     = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_take) begin
			state_q <= chars.last_char ? STATE_RESET : step_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take && chars.last_char) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && chars.last_char)
			fin_s1 <= step_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			value_s2 <= fmt_value;
			err_s2   <= fmt_err;
		end
	end

	assign results.valid      = valid_s2;
	assign results.value      = value_s2;
	assign results.error_code = err_s2;

`ifndef ASSERT_OFF
	// the parse state starts afresh after every final character
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && chars.last_char) |=> (state_q.mode == MODE_PREFIX
			&& state_q.acc == 64'd0 && state_q.err == ERR_OK))
		else $error("parse state not cleared after last character");

	// a finished token always occupies the first register
	a_token_held: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && chars.last_char) |=> valid_s1)
		else $error("finished token lost");

	// rejected tokens carry a zero value
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.error_code == ERR_NEG_NONDEC
			|| results.error_code == ERR_UNKNOWN_BASE)) |-> (results.value == 64'd0))
		else $error("non-zero value on rejected token");
`endif

endmodule

// ----- verif/prnp_result_checker.sv -----
`timescale 1ns / 1ps
// Checker for the prefixed radix number parser: watches both channels, parses
// each accepted character itself and compares every result with its own.
// Depends on prnp_pkg, prnp_char_if and prnp_result_if.
module prnp_result_checker import prnp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	prnp_char_if        chars,
	prnp_result_if      results,
	output int unsigned fail_count,
	output int unsigned tokens_open
);

	typedef struct packed {
		logic [63:0] value;
		err_t        err;
	} parsed_number_t;

	parsed_number_t awaited_numbers[$];

	mode_t       tok_mode;
	logic        tok_neg;
	logic [63:0] tok_acc;
	logic [6:0]  tok_digits;
	err_t        tok_err;

	task automatic clear_token();
		tok_mode   = MODE_PREFIX;
		tok_neg    = 1'b0;
		tok_acc    = 64'd0;
		tok_digits = 7'd0;
		tok_err    = ERR_OK;
	endtask

	// -1 when the character is no digit of the base
	function automatic int digit_value(mode_t m, logic [7:0] c);
		int d;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = int'(c - CH_ZERO);
			if (m == MODE_BIN) return (d < 2) ? d : -1;
			if (m == MODE_OCT) return (d < 8) ? d : -1;
			return d;
		end
		if (m == MODE_HEX) begin
			if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
			if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
		end
		return -1;
	endfunction

	function automatic logic [63:0] to_word(logic [63:0] v);
		logic [63:0] mask;
		mask = (WORD_BITS >= 64) ? '1 : ((64'd1 << WORD_BITS) - 64'd1);
		v &= mask;
		if (WORD_BITS < 64 && v[WORD_BITS-1])
			v |= ~mask;
		return v;
	endfunction

	task automatic parse_char(input logic [7:0] c, input logic last);
		int             d;
		parsed_number_t r;
		case (tok_mode)
			MODE_PREFIX: begin
				if (c == CH_BIN) tok_mode = MODE_BIN;
				else if (c == CH_OCT) tok_mode = MODE_OCT;
				else if (c == CH_HEX) tok_mode = MODE_HEX;
				else if (c == CH_DEC) tok_mode = MODE_DEC;
				else if (c == CH_MINUS) begin
					tok_mode = MODE_MINUS;
					tok_neg  = 1'b1;
				end else begin
					tok_mode = MODE_REJECT;
					tok_err  = ERR_UNKNOWN_BASE;
				end
			end
			MODE_MINUS: begin
				if (c == CH_DEC) tok_mode = MODE_DEC;
				else begin
					tok_mode = MODE_REJECT;
					tok_err  = ERR_NEG_NONDEC;
				end
			end
			MODE_BIN, MODE_OCT, MODE_HEX, MODE_DEC: begin
				d = digit_value(tok_mode, c);
				if (d < 0) begin
					// skip the character; keep any earlier error
					if (tok_err == ERR_OK) tok_err = ERR_BAD_DIGIT;
				end else begin
					case (tok_mode)
						MODE_BIN: tok_acc = (tok_acc << 1) + 64'(d);
						MODE_OCT: tok_acc = (tok_acc << 3) + 64'(d);
						MODE_HEX: tok_acc = (tok_acc << 4) + 64'(d);
						default:  tok_acc = tok_acc * 64'd10 + 64'(d);
					endcase
					if (tok_digits != COUNT_MAX) tok_digits++;
				end
			end
			default: ;
		endcase
		if (!last) return;
		// a token that stops right after the minus is a negative non-decimal
		if (tok_mode == MODE_MINUS) tok_err = ERR_NEG_NONDEC;
		r.err = tok_err;
		if (tok_err == ERR_NEG_NONDEC || tok_err == ERR_UNKNOWN_BASE)
			r.value = 64'd0;
		else begin
			case (tok_mode)
				MODE_BIN: r.value = (tok_digits == 7'(WORD_BITS)) ? to_word(tok_acc) : tok_acc;
				MODE_OCT, MODE_HEX: r.value = to_word(tok_acc);
				MODE_DEC: r.value = tok_neg ? (64'd0 - tok_acc) : tok_acc;
				default: r.value = 64'd0;
			endcase
		end
		awaited_numbers.push_back(r);
		clear_token();
	endtask

	always @(posedge clk or negedge arst_n) begin
		parsed_number_t want;
		if (!arst_n) begin
			clear_token();
			awaited_numbers.delete();
			fail_count  = 0;
			tokens_open = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (awaited_numbers.size() == 0) begin
					$error("unexpected result: value %0d error_code %0d",
						$signed(results.value), results.error_code);
					fail_count++;
				end else begin
					want = awaited_numbers.pop_front();
					if (results.value !== want.value) begin
						$error("value: expected %0d, got %0d",
							$signed(want.value), $signed(results.value));
						fail_count++;
					end
					if (results.error_code !== want.err) begin
						$error("error_code: expected %0d, got %0d",
							want.err, results.error_code);
						fail_count++;
					end
				end
			end
			if (chars.valid && chars.ready)
				parse_char(chars.char_code, chars.last_char);
			tokens_open = awaited_numbers.size();
		end
	end

endmodule

// ----- verif/prefixed_radix_number_parser_core_test.sv -----
`timescale 1ns / 1ps
// Top of the number parser testbench: clock, reset, character tokens and
// result back-pressure, with the verdict. Depends on prnp_pkg, both channel
// interfaces, the parser core and prnp_result_checker.
module prefixed_radix_number_parser_core_test;
	import prnp_pkg::*;

	localparam int CHAR_TARGET = 650;
	localparam int QUIET_LIMIT = 1000;
	localparam int LONG_HOLD   = 90;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned tokens_open;
	int unsigned quiet_cycles = 0;
	int unsigned chars_sent = 0;
	int unsigned send_burst = 0;
	bit          send_idle;
	logic [7:0]  token_chars[$];

	prnp_char_if   chars();
	prnp_result_if results();

	prefixed_radix_number_parser_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.results (results)
	);

	prnp_result_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars),
		.results     (results),
		.fail_count  (fail_count),
		.tokens_open (tokens_open)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		if (send_burst == 0) begin
			send_burst = $urandom_range(20, 80);
			send_idle  = ($urandom_range(0, 2) != 0);
		end
		send_burst--;
		gap = send_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid     <= 1'b1;
		chars.char_code <= c;
		chars.last_char <= last;
		do @(posedge clk); while (!chars.ready);
		chars_sent++;
	endtask

	task automatic send_token();
		foreach (token_chars[i])
			send_char(token_chars[i], i == token_chars.size() - 1);
		token_chars.delete();
	endtask

	// a digit of the base, now and then a random byte instead
	function automatic logic [7:0] pick_digit(mode_t m);
		int v;
		if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
		case (m)
			MODE_BIN: return 8'(CH_ZERO + $urandom_range(0, 1));
			MODE_OCT: return 8'(CH_ZERO + $urandom_range(0, 7));
			MODE_HEX: begin
				v = $urandom_range(0, 15);
				if (v < 10) return 8'(CH_ZERO + v);
				return 8'(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + v - 10);
			end
			default: return 8'(CH_ZERO + $urandom_range(0, 9));
		endcase
	endfunction

	task automatic add_digits(input mode_t m, input int n);
		repeat (n) token_chars.push_back(pick_digit(m));
	endtask

	task automatic add_noise(input int n);
		repeat (n) token_chars.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic make_random_token();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1: begin
				token_chars.push_back(CH_BIN);
				if ($urandom_range(0, 24) == 0) add_digits(MODE_BIN, 130);
				else if ($urandom_range(0, 2) == 0) add_digits(MODE_BIN, WORD_BITS);
				else add_digits(MODE_BIN, $urandom_range(0, 70));
			end
			2: begin
				token_chars.push_back(CH_OCT);
				add_digits(MODE_OCT, $urandom_range(0, 24));
			end
			3, 4: begin
				token_chars.push_back(CH_HEX);
				add_digits(MODE_HEX, $urandom_range(0, 18));
			end
			5: begin
				token_chars.push_back(CH_DEC);
				add_digits(MODE_DEC, $urandom_range(0, 22));
			end
			6: begin
				token_chars.push_back(CH_MINUS);
				token_chars.push_back(CH_DEC);
				add_digits(MODE_DEC, $urandom_range(0, 22));
			end
			7: begin
				token_chars.push_back(CH_MINUS);
				if ($urandom_range(0, 3) != 0) begin
					c = 8'($urandom_range(0, 255));
					if (c == CH_DEC) c = CH_HEX;
					token_chars.push_back(c);
					add_noise($urandom_range(0, 5));
				end
			end
			8: begin
				do c = 8'($urandom_range(0, 255));
				while (c == CH_BIN || c == CH_OCT || c == CH_HEX || c == CH_DEC
					|| c == CH_MINUS);
				token_chars.push_back(c);
				add_noise($urandom_range(0, 5));
			end
			default: add_noise($urandom_range(1, 6));
		endcase
	endtask

	initial begin
		arst_n            = 1'b0;
		chars.valid       = 1'b0;
		chars.char_code   = 8'd0;
		chars.last_char   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// prefix only, bare minus, minus before octal
		token_chars = {CH_BIN};
		send_token();
		token_chars = {CH_MINUS};
		send_token();
		token_chars = {CH_MINUS, CH_OCT, 8'(CH_ZERO + 8'd3)};
		send_token();
		// unknown prefix with the byte extremes
		token_chars = {8'hff, 8'h00};
		send_token();
		// full word of hex in both cases, top bit set
		token_chars = {CH_HEX, CH_LC_F, CH_UC_A, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
			CH_ZERO, CH_NINE};
		send_token();
		// bad digits in octal and binary
		token_chars = {CH_OCT, 8'(CH_ZERO + 8'd2), CH_NINE};
		send_token();
		token_chars = {CH_BIN, 8'(CH_ZERO + 8'd1), CH_ZERO, 8'(CH_ZERO + 8'd2)};
		send_token();
		// negative decimal
		token_chars = {CH_MINUS, CH_DEC, CH_NINE};
		send_token();

		while (chars_sent < CHAR_TARGET) begin
			make_random_token();
			send_token();
		end
		chars.valid <= 1'b0;

		@(negedge clk);
		while (tokens_open != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int          gap;
		int unsigned taken;
		int unsigned recv_burst;
		bit          recv_idle;
		taken         = 0;
		recv_burst    = 0;
		results.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (recv_burst == 0) begin
				recv_burst = $urandom_range(5, 20);
				recv_idle  = ($urandom_range(0, 2) != 0);
			end
			recv_burst--;
			// hold off long enough for the core to fill and stall its input
			if (taken == 12 || taken == 40) gap = LONG_HOLD;
			else gap = recv_idle ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				results.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((chars.valid && chars.ready) || (results.valid && results.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

// ----- prefixed_radix_number_parser_core.f -----
sv/prnp_pkg.sv
sv/prnp_char_if.sv
sv/prnp_result_if.sv
sv/prnp_step.sv
sv/prnp_fmt.sv
sv/prefixed_radix_number_parser_core.sv
verif/prnp_result_checker.sv
verif/prefixed_radix_number_parser_core_test.sv
